// File: hdl/u8u16_pkg.sv
package u8u16_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned PEND_W  = 2;

   localparam logic [UNIT_W-1:0]  UNIT_LIMIT_RESET = 16'hFFFF;
   localparam logic [UNIT_W-1:0]  INVALID_UNIT     = 16'hFFFF;
   localparam logic [UNIT_W-1:0]  TERM_UNIT        = 16'h0000;

   // Lead byte classes: (byte & mask) == code
   localparam logic [BYTE_W-1:0]  ASCII_MASK = 8'h80;
   localparam logic [BYTE_W-1:0]  ASCII_CODE = 8'h00;
   localparam logic [BYTE_W-1:0]  LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0]  LEAD2_CODE = 8'hC0;
   localparam logic [BYTE_W-1:0]  LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0]  LEAD3_CODE = 8'hE0;
   localparam logic [BYTE_W-1:0]  LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0]  LEAD4_CODE = 8'hF0;
   localparam logic [BYTE_W-1:0]  NUL_BYTE   = 8'h00;

   // Pending continuation counts
   localparam logic [PEND_W-1:0]  PEND_NONE  = 2'd0;
   localparam logic [PEND_W-1:0]  PEND_ONE   = 2'd1;
   localparam logic [PEND_W-1:0]  PEND_TWO   = 2'd2;
   localparam logic [PEND_W-1:0]  PEND_THREE = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [UNIT_W-1:0]  code_unit;
      logic               end_of_string;
      logic [COUNT_W-1:0] units_written;
   } rsp_payload_type;

   typedef struct packed {
      logic [PEND_W-1:0]  pending;
      logic [UNIT_W-1:0]  acc;
      logic [COUNT_W-1:0] count;
   } dec_state_type;

   typedef struct packed {
      logic            hit;
      rsp_payload_type word;
   } dec_result_type;

endpackage

// File: hdl/u8u16_stream_if.sv
interface u8u16_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/u8u16_step.sv
module u8u16_step (
   input  u8u16_pkg::dec_state_type             state,
   input  logic [u8u16_pkg::BYTE_W-1:0]         in_byte,
   input  logic [u8u16_pkg::UNIT_W-1:0]         unit_limit,
   output u8u16_pkg::dec_state_type             state_next,
   output u8u16_pkg::dec_result_type            result
);
   import u8u16_pkg::*;

   logic [UNIT_W-1:0] cont_bits;
   logic [UNIT_W-1:0] acc_merged;
   logic              room;
   logic              emit;
   logic [UNIT_W-1:0] emit_value;

   // Continuation payload lands at 6 * (pending - 1), clipped to 16 bits
   always_comb begin
      unique case (state.pending)
         PEND_THREE: cont_bits = {in_byte[3:0], 12'b0};
         PEND_TWO:   cont_bits = {4'b0, in_byte[5:0], 6'b0};
         PEND_ONE:   cont_bits = {10'b0, in_byte[5:0]};
         default:    cont_bits = '0;
      endcase
   end

   assign acc_merged = state.acc | cont_bits;
   assign room = ({1'b0, state.count} + 17'd1) < {1'b0, unit_limit};

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      emit_value = INVALID_UNIT;
      result     = '0;
      priority if (state.pending != PEND_NONE) begin
         state_next.acc     = acc_merged;
         state_next.pending = state.pending - PEND_ONE;
         emit               = (state.pending == PEND_ONE);
         emit_value         = acc_merged;
      end else if (in_byte == NUL_BYTE) begin
         result.hit                 = 1'b1;
         result.word.code_unit      = TERM_UNIT;
         result.word.end_of_string  = 1'b1;
         result.word.units_written  = state.count;
         state_next                 = '0;
      end else if ((in_byte & ASCII_MASK) == ASCII_CODE) begin
         emit       = 1'b1;
         emit_value = {8'b0, in_byte};
      end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
         state_next.acc     = {5'b0, in_byte[4:0], 6'b0};
         state_next.pending = PEND_ONE;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
         state_next.acc     = {in_byte[3:0], 12'b0};
         state_next.pending = PEND_TWO;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
         state_next.acc     = '0;
         state_next.pending = PEND_THREE;
      end else begin
         emit       = 1'b1;
         emit_value = INVALID_UNIT;
      end

      // Drop a finished unit once the buffer is full; keep decoding
      if (emit && room) begin
         result.hit                = 1'b1;
         result.word.code_unit     = emit_value;
         result.word.end_of_string = 1'b0;
         result.word.units_written = state.count;
         state_next.count          = state.count + 16'd1;
      end
   end

endmodule

// File: hdl/utf8_to_utf16_stream_decoder.sv
// A result word shows on rsp in the cycle after its input word is accepted.
// Throughput: one byte per cycle; decode is a single pass from the decoder
//   state and the incoming byte straight into the state and result registers.
// req stalls only while a result word sits in the output register unread.
// Reset (synchronous, active high) clears the decoder state, empties the
//   output register and sets unit_limit back to 65535.
module utf8_to_utf16_stream_decoder (
   input  logic                           clock,
   input  logic                           reset,
   u8u16_stream_if.sink                   req_word,
   u8u16_stream_if.source                 rsp_word,
   input  logic                           csr_wr_en,
   input  logic [u8u16_pkg::UNIT_W-1:0]   csr_wr_data
);
   import u8u16_pkg::*;

   // Decoder state: pending continuations, partial unit, units this string
   dec_state_type     state_ff;
   dec_state_type     state_in;
   dec_result_type    result;

   // Buffer size register, terminator included
   logic [UNIT_W-1:0] limit_ff;

   // Output register
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff;

   logic              req_accept;

   // Take a new word whenever the output register is empty or draining now
   assign req_word.ready = !rsp_valid_ff || rsp_word.ready;
   assign req_accept     = req_word.valid && req_word.ready;

   u8u16_step u_step (
      .state      (state_ff),
      .in_byte    (req_word.payload.in_byte),
      .unit_limit (limit_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         limit_ff     <= UNIT_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (req_accept) begin
            // Advance the decoder; load a result word only when one is due
            state_ff     <= state_in;
            rsp_valid_ff <= result.hit;
         end else if (rsp_word.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload holds while stalled since ready gates every load
   always_ff @(posedge clock) begin
      if (req_accept && result.hit) begin
         rsp_payload_ff <= result.word;
      end
   end

   assign rsp_word.valid   = rsp_valid_ff;
   assign rsp_word.payload = rsp_payload_ff;

endmodule

// File: hdl/u8u16_checker.sv
module u8u16_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  u8u16_pkg::rsp_payload_type  rsp_payload
);
   import u8u16_pkg::*;

   // A result word stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid high after reset");

   // A terminator carries a zero unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_of_string |-> rsp_payload.code_unit == TERM_UNIT)
      else $error("terminator with nonzero code unit");

   // Back-to-back words of one string count up by one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_payload.end_of_string) ##1 rsp_valid
      |-> rsp_payload.units_written == $past(rsp_payload.units_written) + 16'd1)
      else $error("units_written did not advance by one");

endmodule

bind utf8_to_utf16_stream_decoder u8u16_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_word.valid),
   .rsp_ready   (rsp_word.ready),
   .rsp_payload (rsp_word.payload)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import u8u16_pkg::*;

   localparam int unsigned PHASE_COUNT  = 9;
   localparam int unsigned PHASE_BYTES  = 100;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SETTLE       = 4;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned IDLE_PCT     = 12;

   // Tracks the decoder state for one stream and holds the words it owes.
   class unit_tracker;
      logic [PEND_W-1:0]  cont_left;
      logic [UNIT_W-1:0]  partial;
      logic [COUNT_W-1:0] written;
      logic [UNIT_W-1:0]  buf_limit;
      rsp_payload_type    due_units[$];
      int unsigned        errors;

      function new();
         buf_limit = UNIT_LIMIT_RESET;
         errors    = 0;
         clear_string();
      endfunction

      function void clear_string();
         cont_left = PEND_NONE;
         partial   = '0;
         written   = '0;
      endfunction

      function void set_limit(logic [UNIT_W-1:0] v);
         buf_limit = v;
      endfunction

      // Drop the unit once the buffer has room only for the terminator.
      function void emit(logic [UNIT_W-1:0] v);
         rsp_payload_type w;
         if (32'(written) + 1 >= 32'(buf_limit))
            return;
         w.code_unit     = v;
         w.end_of_string = 1'b0;
         w.units_written = written;
         due_units.push_back(w);
         written = written + 1'b1;
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         rsp_payload_type w;
         logic [31:0]     grown;
         int              sh;
         if (cont_left != PEND_NONE) begin
            // Continuation bytes are taken unchecked, a zero byte included.
            sh        = 6 * (int'(cont_left) - 1);
            grown     = {16'h0, partial} | ({26'h0, b[5:0]} << sh);
            partial   = grown[UNIT_W-1:0];
            cont_left = cont_left - 1'b1;
            if (cont_left == PEND_NONE)
               emit(partial);
            return;
         end
         if (b == NUL_BYTE) begin
            w.code_unit     = TERM_UNIT;
            w.end_of_string = 1'b1;
            w.units_written = written;
            due_units.push_back(w);
            clear_string();
         end else if ((b & ASCII_MASK) == ASCII_CODE) begin
            emit({8'h00, b});
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            partial   = {5'b0, b[4:0], 6'b0};
            cont_left = PEND_ONE;
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            partial   = {b[3:0], 12'h000};
            cont_left = PEND_TWO;
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            // Lead bits land above bit 15 and vanish.
            partial   = '0;
            cont_left = PEND_THREE;
         end else begin
            emit(INVALID_UNIT);
         end
      endfunction

      function void check_word(rsp_payload_type got);
         rsp_payload_type want;
         if (due_units.size() == 0) begin
            errors++;
            $display("%0t rsp word with none expected: expected nothing, got %h",
                     $time, got);
            return;
         end
         want = due_units.pop_front();
         if (got.code_unit !== want.code_unit) begin
            errors++;
            $display("%0t code_unit: expected %h, got %h",
                     $time, want.code_unit, got.code_unit);
         end
         if (got.end_of_string !== want.end_of_string) begin
            errors++;
            $display("%0t end_of_string: expected %b, got %b",
                     $time, want.end_of_string, got.end_of_string);
         end
         if (got.units_written !== want.units_written) begin
            errors++;
            $display("%0t units_written: expected %h, got %h",
                     $time, want.units_written, got.units_written);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [UNIT_W-1:0] csr_wr_data;

   // calm: neither side idles; hold_request: receiver backs off for a long stretch
   logic              calm;
   logic              hold_request;
   int unsigned       bytes_sent;
   int unsigned       cycle_count;
   unit_tracker       tracker;

   u8u16_stream_if #(.payload_type(req_payload_type)) req_word ();
   u8u16_stream_if #(.payload_type(rsp_payload_type)) rsp_word ();

   utf8_to_utf16_stream_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Check every result word taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_word.valid && rsp_word.ready)
         tracker.check_word(rsp_word.payload);
   end

   // Receiver: stall at random, or hold off completely when asked so the
   // output register fills and the decoder backs up its input.
   initial begin
      rsp_word.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_word.ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++)
               @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_word.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Offer one byte, with random gaps ahead of it; return at the edge
   // that accepts it.
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      req_payload_type p;
      p.in_byte = b;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_word.valid <= 1'b0;
         @(negedge clock);
      end
      req_word.valid   <= 1'b1;
      req_word.payload <= p;
      @(posedge clock);
      while (!req_word.ready)
         @(posedge clock);
      tracker.note_byte(b);
      bytes_sent++;
   endtask

   // Write the limit only once the decoder has drained.
   task automatic write_limit(input logic [UNIT_W-1:0] v);
      @(negedge clock);
      req_word.valid <= 1'b0;
      while (tracker.due_units.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_limit(v);
   endtask

   function automatic logic [BYTE_W-1:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // One character: mostly well formed with random payload bits, some
   // noise bytes and some sequences cut short.
   task automatic send_char();
      int kind;
      kind = $urandom_range(99);
      if (kind < 35) begin
         push_byte(8'($urandom_range(127, 1)));
      end else if (kind < 50) begin
         push_byte({3'b110, 5'($urandom)});
         push_byte(cont_byte());
      end else if (kind < 62) begin
         push_byte({4'b1110, 4'($urandom)});
         push_byte(cont_byte());
         push_byte(cont_byte());
      end else if (kind < 72) begin
         push_byte({5'b11110, 3'($urandom)});
         repeat (3) push_byte(cont_byte());
      end else if (kind < 88) begin
         push_byte(8'($urandom_range(255, 0)));
      end else begin
         // Truncated multi-byte form: the next character feeds its tail.
         push_byte({4'b1110, 1'b0, 3'($urandom)} | {3'b000, 1'($urandom), 4'h0});
         push_byte(cont_byte());
      end
   endtask

   // Short strings so small limits fill up often; most end in a terminator.
   task automatic send_string();
      int n;
      n = $urandom_range(10, 0);
      repeat (n) send_char();
      if ($urandom_range(9) != 0)
         push_byte(NUL_BYTE);
   endtask

   initial begin
      logic [BYTE_W-1:0] opening[$];
      logic [UNIT_W-1:0] limits[PHASE_COUNT];
      int unsigned       target;

      // Edge bytes, each lead class, invalid leads, a zero byte inside a
      // sequence, then the terminator.
      opening = '{8'h41, 8'h7F, 8'h01,
                  8'hC3, 8'hA9, 8'hDF, 8'hBF,
                  8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF,
                  8'hF0, 8'h9F, 8'h98, 8'h80,
                  8'h80, 8'hF8, 8'hFF,
                  8'hC2, 8'h00,
                  8'h00};
      // Several limits: no room at all, one slot, small buffers, and the top.
      limits = '{16'd3, 16'd1, 16'd0, 16'd2, 16'd7, 16'hFFFF, 16'd5, 16'hFFFE, 16'd4};
      limits[6] = 16'($urandom_range(20, 1));

      tracker        = new();
      calm           = 1'b0;
      hold_request   = 1'b0;
      bytes_sent     = 0;
      cycle_count    = 0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_word.valid   = 1'b0;
      req_word.payload = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i])
         push_byte(opening[i]);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_limit(limits[ph]);
         // One phase runs flat out on both sides.
         calm = (ph == 4);
         // Another starts with the receiver holding off while bytes keep coming.
         if (ph == 5)
            hold_request = 1'b1;
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target)
            send_string();
      end
      calm = 1'b0;

      // Drop valid, then drain whatever is still owed.
      @(negedge clock);
      req_word.valid <= 1'b0;
      while (tracker.due_units.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
